[design/quadratic_probe_hash_set_top_macros.svh]
// Assertion helpers for the hash set block.
// Define ASSERT_OFF to compile all checks away.
`ifndef QUADRATIC_PROBE_HASH_SET_TOP_MACROS_SVH
`define QUADRATIC_PROBE_HASH_SET_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// implication checked in the same cycle
`define QPHS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the next cycle
`define QPHS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define QPHS_ASSERT_IMP(lbl, ante, cons, msg)
`define QPHS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[design/qphs_pkg.sv]
package qphs_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 31;
	localparam int KEY_W         = 31;
	localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
	localparam int SLOT_X_W      = SLOT_W + 1;
	localparam int SLOT_OUT_W    = 5;
	localparam int STATUS_W      = 3;

	localparam logic [SLOT_W-1:0]   LAST_PROBE = SLOT_W'(TABLE_ENTRIES - 1);
	localparam logic [SLOT_X_W-1:0] ENTRIES_X  = SLOT_X_W'(TABLE_ENTRIES);
	localparam logic [KEY_W-1:0]    ENTRIES_K  = KEY_W'(TABLE_ENTRIES);
	localparam logic [SLOT_W-1:0]   STEP_TWO   = SLOT_W'(2);
	localparam logic [SLOT_W-1:0]   STEP_ONE   = SLOT_W'(1);

	// home slot by reciprocal multiply: q = (key * floor(2^SH / N)) >> SH
	localparam int RECIP_SH = KEY_W + 1;
	localparam int RECIP_W  = RECIP_SH;
	localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SH) / 64'(TABLE_ENTRIES);
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_FULL[RECIP_W-1:0];
	localparam int PROD_W = KEY_W + RECIP_W;
	localparam int QN_W   = KEY_W + SLOT_X_W;

	// command queue
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
	localparam logic [CQ_PTR_W-1:0] CQ_LAST = CQ_PTR_W'(CQ_DEPTH - 1);
	localparam logic [CQ_CNT_W-1:0] CQ_FULL = CQ_CNT_W'(CQ_DEPTH);

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND    = 3'd0,
		ST_MISS     = 3'd1,
		ST_INSERTED = 3'd2,
		ST_PRESENT  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic {
		BK_IDLE,
		BK_PROBE
	} back_state_t;

	typedef struct packed {
		logic              func;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] home;
	} cmd_t;

	function automatic logic [SLOT_W-1:0] mod_add(input logic [SLOT_W-1:0] a,
		input logic [SLOT_W-1:0] b);
		logic [SLOT_X_W-1:0] s;
		s = SLOT_X_W'(a) + SLOT_X_W'(b);
		if (s >= ENTRIES_X) begin
			s = s - ENTRIES_X;
		end
		return s[SLOT_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] mod_sub(input logic [SLOT_W-1:0] a,
		input logic [SLOT_W-1:0] b);
		logic [SLOT_X_W-1:0] s;
		s = SLOT_X_W'(a) + ENTRIES_X - SLOT_X_W'(b);
		if (s >= ENTRIES_X) begin
			s = s - ENTRIES_X;
		end
		return s[SLOT_W-1:0];
	endfunction

	// slot on the result port keeps all SLOT_W bits of the slot index
	function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
		logic [31:0] w;
		w = 32'(s);
		return w[SLOT_OUT_W-1:0];
	endfunction

endpackage

[design/qphs_ram.sv]
module qphs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/qphs_front.sv]
module qphs_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           func,
	input  logic [qphs_pkg::KEY_W-1:0]     key,
	output logic                           cq_push,
	output qphs_pkg::cmd_t                 cq_data,
	input  logic                           cq_full
);

	logic en;
	logic v_s1, v_s2, v_s3;
	logic func_s1, func_s2, func_s3;
	logic [qphs_pkg::KEY_W-1:0] key_s1, key_s2, key_s3;
	logic [qphs_pkg::KEY_W-1:0] q_s2;
	logic [qphs_pkg::KEY_W-1:0] qn_s3;

	logic [qphs_pkg::PROD_W-1:0] prod;
	logic [qphs_pkg::QN_W-1:0]   qn_full;
	logic [qphs_pkg::KEY_W-1:0]  rem;

	// whole pipe stalls only when its last stage cannot drain
	assign en   = !(v_s3 && cq_full);
	assign full = !en;

	assign prod    = qphs_pkg::PROD_W'(key_s1) * qphs_pkg::PROD_W'(qphs_pkg::RECIP_M);
	assign qn_full = qphs_pkg::QN_W'(q_s2) * qphs_pkg::QN_W'(qphs_pkg::ENTRIES_X);

	// quotient estimate is low by at most one
	always_comb begin
		rem = key_s3 - qn_s3;
		if (rem >= qphs_pkg::ENTRIES_K) begin
			rem = rem - qphs_pkg::ENTRIES_K;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= func;
			key_s1  <= key;
			func_s2 <= func_s1;
			key_s2  <= key_s1;
			q_s2    <= prod[qphs_pkg::PROD_W-1:qphs_pkg::RECIP_SH];
			func_s3 <= func_s2;
			key_s3  <= key_s2;
			qn_s3   <= qn_full[qphs_pkg::KEY_W-1:0];
		end
	end

	assign cq_push      = v_s3 && !cq_full;
	assign cq_data.func = func_s3;
	assign cq_data.key  = key_s3;
	assign cq_data.home = rem[qphs_pkg::SLOT_W-1:0];

endmodule

[design/qphs_cmd_fifo.sv]
module qphs_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  qphs_pkg::cmd_t din,
	output logic           full,
	input  logic           pop,
	output qphs_pkg::cmd_t dout,
	output logic           empty
);

	qphs_pkg::cmd_t mem_q [qphs_pkg::CQ_DEPTH];
	logic [qphs_pkg::CQ_PTR_W-1:0] wptr_q, rptr_q;
	logic [qphs_pkg::CQ_CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == qphs_pkg::CQ_FULL);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == qphs_pkg::CQ_LAST) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == qphs_pkg::CQ_LAST) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= din;
		end
	end

endmodule

[design/qphs_back.sv]
`include "quadratic_probe_hash_set_top_macros.svh"

module qphs_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cq_empty,
	output logic                              cq_pop,
	input  qphs_pkg::cmd_t                    cq_data,
	input  logic                              pop,
	output logic                              empty,
	output logic [qphs_pkg::STATUS_W-1:0]     status,
	output logic [qphs_pkg::SLOT_OUT_W-1:0]   slot
);

	qphs_pkg::back_state_t state_q, state_d;

	logic                          func_q;
	logic [qphs_pkg::KEY_W-1:0]    key_q;
	logic [qphs_pkg::SLOT_W-1:0]   home_q, s_q, c_q, sq_q, delta_q;
	logic [qphs_pkg::TABLE_ENTRIES-1:0] slot_valid_q;

	logic                          res_v_q;
	qphs_pkg::status_t             res_status_q;
	logic [qphs_pkg::SLOT_W-1:0]   res_slot_q;

	logic [qphs_pkg::SLOT_W-1:0]   sq_n, delta_n, nxt_slot;
	logic                          hit_valid, key_eq, out_free;
	logic                          done;
	qphs_pkg::status_t             done_status;
	logic [qphs_pkg::SLOT_W-1:0]   done_slot;

	logic                          ram_re, ram_we;
	logic [qphs_pkg::SLOT_W-1:0]   ram_raddr;
	logic [qphs_pkg::KEY_W-1:0]    ram_rdata;
	logic                          advance, res_load;

	qphs_ram #(
		.WIDTH(qphs_pkg::KEY_W),
		.DEPTH(qphs_pkg::TABLE_ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(s_q),
		.wdata(key_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign hit_valid = slot_valid_q[s_q];
	assign key_eq    = (ram_rdata == key_q);
	assign out_free  = !res_v_q || pop;

	// odd probe steps move k up: (k+1)^2 = k^2 + (2k+1)
	always_comb begin
		if (!c_q[0]) begin
			sq_n     = qphs_pkg::mod_add(sq_q, delta_q);
			delta_n  = qphs_pkg::mod_add(delta_q, qphs_pkg::STEP_TWO);
			nxt_slot = qphs_pkg::mod_add(home_q, sq_n);
		end else begin
			sq_n     = sq_q;
			delta_n  = delta_q;
			nxt_slot = qphs_pkg::mod_sub(home_q, sq_q);
		end
	end

	always_comb begin
		done        = 1'b1;
		done_status = qphs_pkg::ST_FULL;
		done_slot   = '0;
		priority if (!hit_valid) begin
			done_status = func_q ? qphs_pkg::ST_INSERTED : qphs_pkg::ST_MISS;
			done_slot   = s_q;
		end else if (key_eq) begin
			done_status = func_q ? qphs_pkg::ST_PRESENT : qphs_pkg::ST_FOUND;
			done_slot   = s_q;
		end else if (c_q == qphs_pkg::LAST_PROBE) begin
			done_status = qphs_pkg::ST_FULL;
			done_slot   = '0;
		end else begin
			done = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qphs_pkg::BK_IDLE: begin
				if (!cq_empty) begin
					state_d = qphs_pkg::BK_PROBE;
				end
			end
			qphs_pkg::BK_PROBE: begin
				if (done && out_free) begin
					state_d = qphs_pkg::BK_IDLE;
				end
			end
			default: state_d = qphs_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		cq_pop    = 1'b0;
		advance   = 1'b0;
		res_load  = 1'b0;
		unique case (state_q)
			qphs_pkg::BK_IDLE: begin
				cq_pop = !cq_empty;
			end
			qphs_pkg::BK_PROBE: begin
				advance  = !done;
				res_load = done && out_free;
			end
			default: begin
				cq_pop = 1'b0;
			end
		endcase
		ram_re    = cq_pop || advance;
		ram_raddr = cq_pop ? cq_data.home : nxt_slot;
		ram_we    = res_load && func_q && !hit_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= qphs_pkg::BK_IDLE;
			slot_valid_q <= '0;
			res_v_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				slot_valid_q[s_q] <= 1'b1;
			end
			if (res_load) begin
				res_v_q <= 1'b1;
			end else if (pop) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cq_pop) begin
			func_q  <= cq_data.func;
			key_q   <= cq_data.key;
			home_q  <= cq_data.home;
			s_q     <= cq_data.home;
			c_q     <= '0;
			sq_q    <= '0;
			delta_q <= qphs_pkg::STEP_ONE;
		end else if (advance) begin
			s_q     <= nxt_slot;
			c_q     <= c_q + 1'b1;
			sq_q    <= sq_n;
			delta_q <= delta_n;
		end
		if (res_load) begin
			res_status_q <= done_status;
			res_slot_q   <= done_slot;
		end
	end

	assign empty  = !res_v_q;
	assign status = res_status_q;
	assign slot   = qphs_pkg::slot_out(res_slot_q);

	`QPHS_ASSERT_IMP(a_write_empty_slot, ram_we, !slot_valid_q[s_q], "insert over a live slot")
	`QPHS_ASSERT_NXT(a_insert_marks_valid, ram_we, slot_valid_q[$past(s_q)],
		"inserted slot not marked valid")
	`QPHS_ASSERT_IMP(a_hit_slot_valid,
		res_v_q && (res_status_q == qphs_pkg::ST_FOUND || res_status_q == qphs_pkg::ST_PRESENT),
		slot_valid_q[res_slot_q], "hit reported on an empty slot")
	`QPHS_ASSERT_NXT(a_stall_holds_read, state_q == qphs_pkg::BK_PROBE && done && !out_free,
		$stable(ram_rdata), "probe data lost while result stalled")

endmodule

[design/quadratic_probe_hash_set_top.sv]
// Open-addressed hash set of 31-bit keys with quadratic probing.
// Input channel (push/full): one transfer carries func (0 find, 1 insert)
// and key. Result channel (empty/pop): one transfer per request carries
// status (found, not found, inserted, already present, table full) and slot.
// The front computes the home slot (key mod table size) in three stages by
// reciprocal multiply and hands commands to a two-entry queue. The back walks
// the probe chain +1, -1, +4, -4, ... against the key RAM, one probe a cycle,
// through its single read port. A request takes 1 to table-size probes, and
// the back finishes one request's walk before it pops the next command.
// The result register lets the back start on the next command while a result
// waits; if pop stays low the back holds its last probe, the queue fills and
// full rises until the result is taken.
// Reset (arst_n low) empties the pipeline, queue and result register and
// clears every slot valid mark at once, so the block is usable as soon as
// reset is released; key RAM contents are not cleared.
module quadratic_probe_hash_set_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            func,
	input  logic [qphs_pkg::KEY_W-1:0]      key,
	output logic                            empty,
	input  logic                            pop,
	output logic [qphs_pkg::STATUS_W-1:0]   status,
	output logic [qphs_pkg::SLOT_OUT_W-1:0] slot
);

	// front -> queue
	logic           fq_push;
	qphs_pkg::cmd_t fq_data;
	logic           fq_full;

	// queue -> back
	logic           bq_pop;
	qphs_pkg::cmd_t bq_data;
	logic           bq_empty;

	qphs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.func   (func),
		.key    (key),
		.cq_push(fq_push),
		.cq_data(fq_data),
		.cq_full(fq_full)
	);

	// decouples home-slot computation from the probe walk
	qphs_cmd_fifo u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fq_push),
		.din   (fq_data),
		.full  (fq_full),
		.pop   (bq_pop),
		.dout  (bq_data),
		.empty (bq_empty)
	);

	qphs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cq_empty(bq_empty),
		.cq_pop  (bq_pop),
		.cq_data (bq_data),
		.pop     (pop),
		.empty   (empty),
		.status  (status),
		.slot    (slot)
	);

endmodule
